### sv/saq_alu_pkg.sv
// ----------------------------------------------------------------------------
// saq_alu_pkg
// Opcodes, result types and helper functions for the saturating Q15/Q31 ALU.
// ----------------------------------------------------------------------------
package saq_alu_pkg;

    localparam int OP_W           = 5;
    localparam int DIV_W          = 15;
    localparam int DIV_STEPS_STG  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_SATURATE  = 5'd0,
        OP_ADD       = 5'd1,
        OP_SUB       = 5'd2,
        OP_ABS_S     = 5'd3,
        OP_SHR       = 5'd4,
        OP_SHL       = 5'd5,
        OP_MULT      = 5'd6,
        OP_MULT_R    = 5'd7,
        OP_L_MULT    = 5'd8,
        OP_NEGATE    = 5'd9,
        OP_EXTRACT_H = 5'd10,
        OP_EXTRACT_L = 5'd11,
        OP_ROUND     = 5'd12,
        OP_L_MAC     = 5'd13,
        OP_L_MSU     = 5'd14,
        OP_L_ADD     = 5'd15,
        OP_L_SUB     = 5'd16,
        OP_L_NEGATE  = 5'd17,
        OP_L_SHL     = 5'd18,
        OP_L_SHR     = 5'd19,
        OP_L_ABS     = 5'd20,
        OP_L_DEP_H   = 5'd21,
        OP_L_DEP_L   = 5'd22,
        OP_NORM_S    = 5'd23,
        OP_NORM_L    = 5'd24,
        OP_DIV_S     = 5'd25,
        OP_CLR_OVF   = 5'd26
    } t_op;

    localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;
    localparam logic signed [15:0] MAX16 = 16'sh7fff;
    localparam logic signed [15:0] MIN16 = 16'sh8000;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_sat;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] quot;
    } t_div_st;

    function automatic t_sat sat16(input logic signed [32:0] x);
        t_sat r;
        r.ovf = 1'b0;
        if (x > 33'sd32767) begin
            r.ovf = 1'b1;
            r.val = {{16{1'b0}}, MAX16};
        end else if (x < -33'sd32768) begin
            r.ovf = 1'b1;
            r.val = {{16{1'b1}}, MIN16};
        end else begin
            r.val = {{16{x[15]}}, x[15:0]};
        end
        return r;
    endfunction

    function automatic t_sat sat32(input logic signed [32:0] x);
        t_sat r;
        r.ovf = 1'b0;
        if (x > 33'sd2147483647) begin
            r.ovf = 1'b1;
            r.val = MAX32;
        end else if (x < -33'sd2147483648) begin
            r.ovf = 1'b1;
            r.val = MIN32;
        end else begin
            r.val = x[31:0];
        end
        return r;
    endfunction

    // k >= 0 shifts right, k < 0 shifts left by -k
    function automatic t_sat shift16(input logic signed [15:0] v,
                                     input logic signed [16:0] k);
        t_sat               r;
        logic [3:0]         amt;
        logic signed [16:0] lft;
        logic signed [15:0] sh;
        logic signed [31:0] wide;
        r.ovf = 1'b0;
        lft   = -k;
        if (!k[16]) begin
            amt   = (k > 17'sd15) ? 4'd15 : k[3:0];
            sh    = v >>> amt;
            r.val = {{16{sh[15]}}, sh};
        end else if (lft > 17'sd15) begin
            if (v == 16'sd0) begin
                r.val = '0;
            end else begin
                r.ovf = 1'b1;
                r.val = v[15] ? {{16{1'b1}}, MIN16} : {{16{1'b0}}, MAX16};
            end
        end else begin
            wide = {{16{v[15]}}, v} <<< lft[3:0];
            if (wide > 32'sd32767 || wide < -32'sd32768) begin
                r.ovf = 1'b1;
                r.val = v[15] ? {{16{1'b1}}, MIN16} : {{16{1'b0}}, MAX16};
            end else begin
                r.val = wide;
            end
        end
        return r;
    endfunction

    function automatic t_sat shift32(input logic signed [31:0] v,
                                     input logic signed [16:0] k);
        t_sat               r;
        logic [4:0]         amt;
        logic [5:0]         lamt;
        logic signed [16:0] lft;
        logic signed [63:0] wide;
        r.ovf = 1'b0;
        lft   = -k;
        if (!k[16]) begin
            amt   = (k > 17'sd31) ? 5'd31 : k[4:0];
            r.val = v >>> amt;
        end else begin
            lamt = (lft > 17'sd32) ? 6'd32 : lft[5:0];
            wide = {{32{v[31]}}, v} <<< lamt;
            if (wide > 64'sh7fffffff || wide < -64'sh80000000) begin
                r.ovf = 1'b1;
                r.val = v[31] ? MIN32 : MAX32;
            end else begin
                r.val = wide[31:0];
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] norm16(input logic [15:0] v);
        logic [15:0] x;
        logic [4:0]  cnt;
        x   = v[15] ? ~v : v;
        cnt = 5'd16;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) cnt = 5'(15 - i);
        end
        return (v == '0) ? 5'd0 : 5'(cnt - 5'd1);
    endfunction

    function automatic logic [5:0] norm32(input logic [31:0] v);
        logic [31:0] x;
        logic [5:0]  cnt;
        x   = v[31] ? ~v : v;
        cnt = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) cnt = 6'(31 - i);
        end
        return (v == '0) ? 6'd0 : 6'(cnt - 6'd1);
    endfunction

    // restoring divide, DIV_STEPS_STG (five) quotient bits per call
    function automatic t_div_st div_steps(input t_div_st s,
                                          input logic [DIV_W-1:0] den);
        t_div_st      r;
        logic [DIV_W:0] dbl;
        r = s;
        for (int i = 0; i < DIV_STEPS_STG; i++) begin
            dbl = {r.num, 1'b0};
            if (dbl >= {1'b0, den}) begin
                dbl    = dbl - {1'b0, den};
                r.quot = {r.quot[DIV_W-2:0], 1'b1};
            end else begin
                r.quot = {r.quot[DIV_W-2:0], 1'b0};
            end
            r.num = dbl[DIV_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/saq_div.sv
// ----------------------------------------------------------------------------
// saq_div
// Three-stage restoring divider for div_s, five quotient bits per stage.
// ----------------------------------------------------------------------------
module saq_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [saq_alu_pkg::DIV_W-1:0] i_num,
    input  logic [saq_alu_pkg::DIV_W-1:0] i_den,
    output logic [saq_alu_pkg::DIV_W-1:0] o_quot
);

    saq_alu_pkg::t_div_st          r_a_st, r_b_st, n_a_st, n_b_st, w_c_st, w_init;
    logic [saq_alu_pkg::DIV_W-1:0] r_a_den, r_b_den;

    always_comb begin
        w_init.num  = i_num;
        w_init.quot = '0;
        n_a_st      = saq_alu_pkg::div_steps(w_init, i_den);
        n_b_st      = saq_alu_pkg::div_steps(r_a_st, r_a_den);
        w_c_st      = saq_alu_pkg::div_steps(r_b_st, r_b_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_st  <= n_a_st;
            r_a_den <= i_den;
            r_b_st  <= n_b_st;
            r_b_den <= r_a_den;
        end
    end

    assign o_quot = w_c_st.quot;

endmodule

### sv/saturating_q15_q31_alu.sv
// ----------------------------------------------------------------------------
// saturating_q15_q31_alu
// Saturating Q15/Q31 basic-operator ALU with sticky overflow.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the output is not stalled; each beat
// passes stage 1, 2 and 3 and the output register. Stage 1 registers the
// operands; stage 2 holds the adders, shifters, normalizers and the 16x16
// product; stage 3 finishes the multiply-based operations (mult, mult_r,
// L_mult, L_mac, L_msu); the output register applies the sticky overflow in
// beat order. div_s runs beside this as a 15-step restoring divider, five
// quotient bits in each of three stages. A stall on the output freezes the
// whole pipeline; o_stall follows i_stall only while a result is held.
// Sticky overflow is read out with each beat; opcode 26 clears it.
module saturating_q15_q31_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [4:0]         i_req_type,
    input  logic signed [31:0] i_long_a,
    input  logic signed [31:0] i_long_b,
    input  logic signed [15:0] i_short_a,
    input  logic signed [15:0] i_short_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_value,
    output logic               o_overflow_flag,
    output logic               o_domain_error
);

    logic w_adv;

    // stage 1: operands
    logic                  r_s1_valid;
    logic [4:0]            r_s1_op;
    logic signed [31:0]    r_s1_la, r_s1_lb;
    logic signed [15:0]    r_s1_sa, r_s1_sb;

    // stage 2
    logic                  r_s2_valid;
    logic [4:0]            r_s2_op;
    saq_alu_pkg::t_sat     r_s2_res, n_s2_res;
    logic signed [31:0]    r_s2_prod;
    logic signed [31:0]    r_s2_la;
    logic                  r_s2_derr, n_s2_derr;

    // stage 3
    logic                  r_s3_valid;
    logic [4:0]            r_s3_op;
    saq_alu_pkg::t_sat     r_s3_res, n_s3_res;
    logic                  r_s3_derr;

    // output
    logic                  r_o_valid;
    logic signed [31:0]    r_o_res, n_o_res;
    logic                  r_o_ovf, n_o_ovf;
    logic                  r_o_derr, n_o_derr;
    logic                  r_sticky, n_sticky;

    logic [saq_alu_pkg::DIV_W-1:0] w_quot;

    assign w_adv   = !(r_o_valid && i_stall);
    assign o_stall = r_o_valid && i_stall;

    // ---------------- stage 1 -> 2 ----------------
    logic signed [16:0] w_sb17;

    always_comb begin
        w_sb17    = {r_s1_sb[15], r_s1_sb};
        n_s2_res  = '0;
        n_s2_derr = 1'b0;
        case (r_s1_op)
            saq_alu_pkg::OP_SATURATE:
                n_s2_res = saq_alu_pkg::sat16({r_s1_la[31], r_s1_la});
            saq_alu_pkg::OP_ADD:
                n_s2_res = saq_alu_pkg::sat16(33'(r_s1_sa) + 33'(r_s1_sb));
            saq_alu_pkg::OP_SUB:
                n_s2_res = saq_alu_pkg::sat16(33'(r_s1_sa) - 33'(r_s1_sb));
            saq_alu_pkg::OP_ABS_S: begin
                if (r_s1_sa == saq_alu_pkg::MIN16)
                    n_s2_res.val = 32'(saq_alu_pkg::MAX16);
                else if (r_s1_sa[15])
                    n_s2_res.val = -32'(r_s1_sa);
                else
                    n_s2_res.val = 32'(r_s1_sa);
            end
            saq_alu_pkg::OP_SHR:
                n_s2_res = saq_alu_pkg::shift16(r_s1_sa, w_sb17);
            saq_alu_pkg::OP_SHL:
                n_s2_res = saq_alu_pkg::shift16(r_s1_sa, -w_sb17);
            saq_alu_pkg::OP_NEGATE: begin
                if (r_s1_sa == saq_alu_pkg::MIN16)
                    n_s2_res.val = 32'(saq_alu_pkg::MAX16);
                else
                    n_s2_res.val = -32'(r_s1_sa);
            end
            saq_alu_pkg::OP_EXTRACT_H:
                n_s2_res.val = {{16{r_s1_la[31]}}, r_s1_la[31:16]};
            saq_alu_pkg::OP_EXTRACT_L:
                n_s2_res.val = {{16{r_s1_la[15]}}, r_s1_la[15:0]};
            saq_alu_pkg::OP_ROUND: begin
                n_s2_res = saq_alu_pkg::sat32(33'(r_s1_la) + 33'sh8000);
                n_s2_res.val = {{16{n_s2_res.val[31]}}, n_s2_res.val[31:16]};
            end
            saq_alu_pkg::OP_L_ADD:
                n_s2_res = saq_alu_pkg::sat32(33'(r_s1_la) + 33'(r_s1_lb));
            saq_alu_pkg::OP_L_SUB:
                n_s2_res = saq_alu_pkg::sat32(33'(r_s1_la) - 33'(r_s1_lb));
            saq_alu_pkg::OP_L_NEGATE: begin
                if (r_s1_la == saq_alu_pkg::MIN32)
                    n_s2_res.val = saq_alu_pkg::MAX32;
                else
                    n_s2_res.val = -r_s1_la;
            end
            saq_alu_pkg::OP_L_SHL:
                n_s2_res = saq_alu_pkg::shift32(r_s1_la, -w_sb17);
            saq_alu_pkg::OP_L_SHR:
                n_s2_res = saq_alu_pkg::shift32(r_s1_la, w_sb17);
            saq_alu_pkg::OP_L_ABS: begin
                if (r_s1_la == saq_alu_pkg::MIN32)
                    n_s2_res.val = saq_alu_pkg::MAX32;
                else if (r_s1_la[31])
                    n_s2_res.val = -r_s1_la;
                else
                    n_s2_res.val = r_s1_la;
            end
            saq_alu_pkg::OP_L_DEP_H:
                n_s2_res.val = {r_s1_sa, 16'h0000};
            saq_alu_pkg::OP_L_DEP_L:
                n_s2_res.val = 32'(r_s1_sa);
            saq_alu_pkg::OP_NORM_S:
                n_s2_res.val = {27'd0, saq_alu_pkg::norm16(r_s1_sa)};
            saq_alu_pkg::OP_NORM_L:
                n_s2_res.val = {26'd0, saq_alu_pkg::norm32(r_s1_la)};
            saq_alu_pkg::OP_DIV_S:
                n_s2_derr = r_s1_sa[15] || r_s1_sb[15] || (r_s1_sb == 16'sd0)
                            || (r_s1_sa > r_s1_sb);
            default: n_s2_res = '0;  // multiply ops, clear, unused codes
        endcase
    end

    // ---------------- stage 2 -> 3 ----------------
    logic               w_lm_ovf;
    logic signed [31:0] w_lm;
    logic signed [32:0] w_prod33;

    always_comb begin
        w_prod33 = {r_s2_prod[31], r_s2_prod};
        w_lm_ovf = (r_s2_prod == 32'sh40000000);
        w_lm     = w_lm_ovf ? saq_alu_pkg::MAX32 : (r_s2_prod <<< 1);
        n_s3_res = r_s2_res;
        case (r_s2_op)
            saq_alu_pkg::OP_MULT:
                n_s3_res = saq_alu_pkg::sat16(w_prod33 >>> 15);
            saq_alu_pkg::OP_MULT_R:
                n_s3_res = saq_alu_pkg::sat16((w_prod33 + 33'sh4000) >>> 15);
            saq_alu_pkg::OP_L_MULT: begin
                n_s3_res.val = w_lm;
                n_s3_res.ovf = w_lm_ovf;
            end
            saq_alu_pkg::OP_L_MAC: begin
                n_s3_res     = saq_alu_pkg::sat32(33'(r_s2_la) + 33'(w_lm));
                n_s3_res.ovf = n_s3_res.ovf | w_lm_ovf;
            end
            saq_alu_pkg::OP_L_MSU: begin
                n_s3_res     = saq_alu_pkg::sat32(33'(r_s2_la) - 33'(w_lm));
                n_s3_res.ovf = n_s3_res.ovf | w_lm_ovf;
            end
            default: n_s3_res = r_s2_res;
        endcase
    end

    // ---------------- stage 3 -> output ----------------
    always_comb begin
        n_o_res  = r_s3_res.val;
        n_o_derr = 1'b0;
        n_sticky = r_sticky | r_s3_res.ovf;
        if (r_s3_op == saq_alu_pkg::OP_DIV_S) begin
            n_o_derr = r_s3_derr;
            n_o_res  = r_s3_derr ? 32'sd0 : {17'd0, w_quot};
            n_sticky = r_sticky;
        end else if (r_s3_op == saq_alu_pkg::OP_CLR_OVF) begin
            n_sticky = 1'b0;
        end
        n_o_ovf = n_sticky;
    end

    saq_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r_s1_sa[saq_alu_pkg::DIV_W-1:0]),
        .i_den  (r_s1_sb[saq_alu_pkg::DIV_W-1:0]),
        .o_quot (w_quot)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_sticky   <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_o_valid  <= r_s3_valid;
            if (r_s3_valid) r_sticky <= n_sticky;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_op   <= i_req_type;
            r_s1_la   <= i_long_a;
            r_s1_lb   <= i_long_b;
            r_s1_sa   <= i_short_a;
            r_s1_sb   <= i_short_b;
            r_s2_op   <= r_s1_op;
            r_s2_res  <= n_s2_res;
            r_s2_derr <= n_s2_derr;
            r_s2_prod <= 32'(r_s1_sa) * 32'(r_s1_sb);
            r_s2_la   <= r_s1_la;
            r_s3_op   <= r_s2_op;
            r_s3_res  <= n_s3_res;
            r_s3_derr <= r_s2_derr;
            r_o_res   <= n_o_res;
            r_o_ovf   <= n_o_ovf;
            r_o_derr  <= n_o_derr;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_result_value  = r_o_res;
    assign o_overflow_flag = r_o_ovf;
    assign o_domain_error  = r_o_derr;

endmodule
